### src/isoep_pkg.sv
// isoep_pkg: shared types and field widths for the timestamp to epoch converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package isoep_pkg;

  localparam int YEAR_W   = 14;
  localparam int FIELD_W  = 7;
  localparam int MILLIS_W = 10;
  localparam int FCNT_W   = 2;

  // one parsed timestamp handed from the parser to the converter
  typedef struct packed {
    logic                ok;
    logic [YEAR_W-1:0]   year;
    logic [FIELD_W-1:0]  month;
    logic [FIELD_W-1:0]  day;
    logic [FIELD_W-1:0]  hour;
    logic [FIELD_W-1:0]  minute;
    logic [FIELD_W-1:0]  second;
    logic [MILLIS_W-1:0] millis;
    logic [FCNT_W-1:0]   frac_cnt;
    logic                zone_neg;
    logic [FIELD_W-1:0]  zone_hour;
    logic [FIELD_W-1:0]  zone_minute;
  } rec_t;

endpackage

`default_nettype wire

### src/iso_timestamp_to_epoch_ms_core.sv
// iso_timestamp_to_epoch_ms_core: top level of the timestamp to epoch converter
// depends on isoep_pkg, isoep_front, isoep_queue, isoep_back
`timescale 1ns / 1ps
`default_nettype none

// Takes an ISO-8601 timestamp one character per transfer and gives one result
// (valid flag and UTC epoch milliseconds) per timestamp, which last_char ends.
// The parser takes a character every cycle. Each finished timestamp goes into
// a queue of QUEUE_DEPTH entries; the converter finishes one entry before it
// pops the next (a sequencer stepping through the divide by 400, day count and
// millisecond scaling) and holds the result in an output register. A well-formed
// timestamp has at least 19 characters and flows at one character per cycle;
// short malformed text or a stalled result can fill the queue, and the input
// stalls only while the queue is full.

module iso_timestamp_to_epoch_ms_core import isoep_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [47:0] epoch_ms
);

  logic push;
  rec_t push_rec;
  logic q_full;
  logic q_valid;
  rec_t q_rec;
  logic pop;

  isoep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  isoep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_rec  (q_rec)
  );

  isoep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .epoch_ms  (epoch_ms)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> epoch_ms == 48'd0)
    else $error("invalid result with nonzero epoch_ms");

  a_ms_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> epoch_ms <= 48'd253402387139999)
    else $error("epoch_ms beyond largest representable timestamp");

  a_stall_queue: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled while queue is empty");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

`default_nettype wire

### src/isoep_front.sv
// isoep_front: character parser, one character per transfer
// depends on isoep_pkg; hands one rec_t per timestamp to the queue
`timescale 1ns / 1ps
`default_nettype none

module isoep_front import isoep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       q_full,
  output logic       push,
  output rec_t       push_rec
);

  typedef enum logic [1:0] {PH_FIXED, PH_AFTER_SEC, PH_FRAC, PH_ZONE} phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  localparam logic [4:0] POS_DASH1  = 5'd4;
  localparam logic [4:0] POS_DASH2  = 5'd7;
  localparam logic [4:0] POS_TSEP   = 5'd10;
  localparam logic [4:0] POS_COLON1 = 5'd13;
  localparam logic [4:0] POS_COLON2 = 5'd16;
  localparam logic [4:0] POS_LAST   = 5'd18;
  localparam logic [4:0] ZPOS_COLON = 5'd2;
  localparam logic [4:0] ZPOS_LAST  = 5'd4;
  localparam logic [FCNT_W-1:0] FRAC_MAX = 2'd3;

  logic [4:0]          pos, pos_next;
  phase_t              phase, phase_next;
  logic                failed, failed_next;
  logic                suffix_done, suffix_done_next;
  logic [YEAR_W-1:0]   year_acc, year_acc_next;
  logic [FIELD_W-1:0]  month_acc, month_acc_next;
  logic [FIELD_W-1:0]  day_acc, day_acc_next;
  logic [FIELD_W-1:0]  hour_acc, hour_acc_next;
  logic [FIELD_W-1:0]  minute_acc, minute_acc_next;
  logic [FIELD_W-1:0]  second_acc, second_acc_next;
  logic [MILLIS_W-1:0] millis_acc, millis_acc_next;
  logic [FCNT_W-1:0]   frac_cnt, frac_cnt_next;
  logic                zone_neg, zone_neg_next;
  logic [FIELD_W-1:0]  zone_hour_acc, zone_hour_acc_next;
  logic [FIELD_W-1:0]  zone_minute_acc, zone_minute_acc_next;

  logic       accept;
  logic       is_dig;
  logic [3:0] dig;
  logic       do_suffix;
  logic       fin_failed;
  logic       fin_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && last_char;
  assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dig      = char_code[3:0];

  always_comb begin
    pos_next             = pos;
    phase_next           = phase;
    failed_next          = failed;
    suffix_done_next     = suffix_done;
    year_acc_next        = year_acc;
    month_acc_next       = month_acc;
    day_acc_next         = day_acc;
    hour_acc_next        = hour_acc;
    minute_acc_next      = minute_acc;
    second_acc_next      = second_acc;
    millis_acc_next      = millis_acc;
    frac_cnt_next        = frac_cnt;
    zone_neg_next        = zone_neg;
    zone_hour_acc_next   = zone_hour_acc;
    zone_minute_acc_next = zone_minute_acc;
    do_suffix            = 1'b0;

    if (!failed && !suffix_done) begin
      case (phase)
        PH_FIXED: begin
          case (pos) inside
            POS_DASH1, POS_DASH2: begin
              if (char_code != CH_DASH) failed_next = 1'b1;
            end
            POS_TSEP: begin
              if (char_code != CH_T && char_code != CH_SPACE) failed_next = 1'b1;
            end
            POS_COLON1, POS_COLON2: begin
              if (char_code != CH_COLON) failed_next = 1'b1;
            end
            default: begin
              if (!is_dig) begin
                failed_next = 1'b1;
              end else if (pos < POS_DASH1) begin
                year_acc_next = YEAR_W'(year_acc * YEAR_W'(10) + YEAR_W'(dig));
              end else if (pos < POS_DASH2) begin
                month_acc_next = FIELD_W'(month_acc * FIELD_W'(10) + FIELD_W'(dig));
              end else if (pos < POS_TSEP) begin
                day_acc_next = FIELD_W'(day_acc * FIELD_W'(10) + FIELD_W'(dig));
              end else if (pos < POS_COLON1) begin
                hour_acc_next = FIELD_W'(hour_acc * FIELD_W'(10) + FIELD_W'(dig));
              end else if (pos < POS_COLON2) begin
                minute_acc_next = FIELD_W'(minute_acc * FIELD_W'(10) + FIELD_W'(dig));
              end else begin
                second_acc_next = FIELD_W'(second_acc * FIELD_W'(10) + FIELD_W'(dig));
              end
            end
          endcase
          if (!failed_next) begin
            if (pos == POS_LAST) begin
              phase_next = PH_AFTER_SEC;
              pos_next   = '0;
            end else begin
              pos_next = pos + 5'd1;
            end
          end
        end
        PH_AFTER_SEC: begin
          if (char_code == CH_DOT) phase_next = PH_FRAC;
          else do_suffix = 1'b1;
        end
        PH_FRAC: begin
          if (is_dig) begin
            if (frac_cnt < FRAC_MAX) begin
              millis_acc_next = MILLIS_W'(millis_acc * MILLIS_W'(10) + MILLIS_W'(dig));
              frac_cnt_next   = frac_cnt + 2'd1;
            end
          end else begin
            do_suffix = 1'b1;
          end
        end
        PH_ZONE: begin
          if (pos == ZPOS_COLON) begin
            if (char_code != CH_COLON) failed_next = 1'b1;
          end else if (!is_dig) begin
            failed_next = 1'b1;
          end else if (pos < ZPOS_COLON) begin
            zone_hour_acc_next = FIELD_W'(zone_hour_acc * FIELD_W'(10) + FIELD_W'(dig));
          end else begin
            zone_minute_acc_next = FIELD_W'(zone_minute_acc * FIELD_W'(10) + FIELD_W'(dig));
          end
          if (!failed_next) begin
            pos_next = pos + 5'd1;
            if (pos == ZPOS_LAST) suffix_done_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase

      if (do_suffix) begin
        if (char_code == CH_Z || char_code == CH_NUL) begin
          suffix_done_next = 1'b1;
        end else if (char_code == CH_PLUS || char_code == CH_DASH) begin
          zone_neg_next = (char_code == CH_DASH);
          phase_next    = PH_ZONE;
          pos_next      = '0;
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    // end of text right after seconds or fraction counts as utc
    fin_failed = failed_next;
    fin_done   = suffix_done_next;
    if (!failed_next && !suffix_done_next) begin
      if (phase_next == PH_AFTER_SEC || phase_next == PH_FRAC) fin_done = 1'b1;
      else fin_failed = 1'b1;
    end

    push_rec.ok          = !fin_failed && fin_done;
    push_rec.year        = year_acc_next;
    push_rec.month       = month_acc_next;
    push_rec.day         = day_acc_next;
    push_rec.hour        = hour_acc_next;
    push_rec.minute      = minute_acc_next;
    push_rec.second      = second_acc_next;
    push_rec.millis      = millis_acc_next;
    push_rec.frac_cnt    = frac_cnt_next;
    push_rec.zone_neg    = zone_neg_next;
    push_rec.zone_hour   = zone_hour_acc_next;
    push_rec.zone_minute = zone_minute_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos             <= '0;
      phase           <= PH_FIXED;
      failed          <= 1'b0;
      suffix_done     <= 1'b0;
      year_acc        <= '0;
      month_acc       <= '0;
      day_acc         <= '0;
      hour_acc        <= '0;
      minute_acc      <= '0;
      second_acc      <= '0;
      millis_acc      <= '0;
      frac_cnt        <= '0;
      zone_neg        <= 1'b0;
      zone_hour_acc   <= '0;
      zone_minute_acc <= '0;
    end else if (accept) begin
      pos             <= pos_next;
      phase           <= phase_next;
      failed          <= failed_next;
      suffix_done     <= suffix_done_next;
      year_acc        <= year_acc_next;
      month_acc       <= month_acc_next;
      day_acc         <= day_acc_next;
      hour_acc        <= hour_acc_next;
      minute_acc      <= minute_acc_next;
      second_acc      <= second_acc_next;
      millis_acc      <= millis_acc_next;
      frac_cnt        <= frac_cnt_next;
      zone_neg        <= zone_neg_next;
      zone_hour_acc   <= zone_hour_acc_next;
      zone_minute_acc <= zone_minute_acc_next;
    end
  end

endmodule

`default_nettype wire

### src/isoep_queue.sv
// isoep_queue: small fifo of parsed timestamps between parser and converter
// depends on isoep_pkg for rec_t
`timescale 1ns / 1ps
`default_nettype none

module isoep_queue import isoep_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic valid,
  output rec_t pop_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rec_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/isoep_back.sv
// isoep_back: range checks and days-from-civil; one step per unstalled cycle
// depends on isoep_pkg; drains rec_t from the queue, owns the result register
`timescale 1ns / 1ps
`default_nettype none

module isoep_back import isoep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  rec_t        q_rec,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [47:0] epoch_ms
);

  typedef enum logic [3:0] {
    S_IDLE, S_QYEAR, S_RYEAR, S_QADJ, S_RADJ, S_DOE, S_DAYS,
    S_SECS1, S_SECS2, S_MS1, S_MS2, S_OUT
  } state_t;

  localparam logic [YEAR_W-1:0] YEAR_MIN     = YEAR_W'(1970);
  localparam logic [12:0]       DIV400_MUL   = 13'd5243;
  localparam int                DIV400_SHIFT = 21;
  localparam int                PROD_W       = YEAR_W + 13;
  localparam logic [24:0]       DAYS_PER_ERA = 25'd146097;
  localparam logic [24:0]       EPOCH_OFFSET = 25'd719468;

  function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the month in a year that starts in march
  function automatic logic [8:0] month_offset(input logic [FIELD_W-1:0] m);
    logic [8:0] off;
    case (m)
      7'd3:    off = 9'd0;
      7'd4:    off = 9'd31;
      7'd5:    off = 9'd61;
      7'd6:    off = 9'd92;
      7'd7:    off = 9'd122;
      7'd8:    off = 9'd153;
      7'd9:    off = 9'd184;
      7'd10:   off = 9'd214;
      7'd11:   off = 9'd245;
      7'd12:   off = 9'd275;
      7'd1:    off = 9'd306;
      7'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  state_t               state;
  rec_t                 rec;
  logic [5:0]           q_r;
  logic [8:0]           yoe_r;
  logic [5:0]           era_r;
  logic [8:0]           doy_r;
  logic [17:0]          doe_r;
  logic                 ok_r;
  logic signed [24:0]   days_r;
  logic signed [42:0]   dsec_r;
  logic [18:0]          tod_r;
  logic [18:0]          zone_r;
  logic [9:0]           frac_r;
  logic signed [42:0]   secs_r;
  logic                 neg_r;
  logic [47:0]          m24_r;
  logic                 res_valid;
  logic [47:0]          res_ms;

  logic [YEAR_W-1:0]    year_adj;
  logic [YEAR_W-1:0]    div_in;
  logic [PROD_W-1:0]    div_prod;
  logic [14:0]          rem_full;
  logic [8:0]           rem;
  logic                 leap;
  logic [4:0]           mlen;
  logic [1:0]           c100;
  logic [24:0]          days_u;
  logic [47:0]          secs48;
  logic [47:0]          ms_sum;

  assign pop      = (state == S_IDLE) && q_valid;
  assign year_adj = rec.year - ((rec.month <= 7'd2) ? YEAR_W'(1) : YEAR_W'(0));
  assign div_in   = (state == S_QYEAR || state == S_RYEAR) ? rec.year : year_adj;
  assign div_prod = PROD_W'(div_in) * PROD_W'(DIV400_MUL);
  assign rem_full = 15'(div_in) - 15'(q_r) * 15'd400;
  assign rem      = rem_full[8:0];
  assign leap     = (rem == 9'd0) ||
                    ((rec.year[1:0] == 2'd0) &&
                     !(rem == 9'd100 || rem == 9'd200 || rem == 9'd300));
  assign mlen     = month_len(rec.month, leap);
  assign c100     = 2'((yoe_r >= 9'd100) ? 1 : 0) + 2'((yoe_r >= 9'd200) ? 1 : 0) +
                    2'((yoe_r >= 9'd300) ? 1 : 0);
  assign days_u   = 25'(era_r) * DAYS_PER_ERA + 25'(doe_r);
  assign secs48   = 48'(secs_r);
  assign ms_sum   = (secs48 << 10) - m24_r + 48'(frac_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            rec   <= q_rec;
            state <= S_QYEAR;
          end
        end
        S_QYEAR: begin
          q_r   <= div_prod[PROD_W-1:DIV400_SHIFT];
          state <= S_RYEAR;
        end
        S_RYEAR: begin
          ok_r <= rec.ok && (rec.year >= YEAR_MIN) && (rec.month >= 7'd1) &&
                  (rec.month <= 7'd12) && (rec.day >= 7'd1) &&
                  (rec.day <= 7'(mlen)) && (rec.hour <= 7'd23) &&
                  (rec.minute <= 7'd59) && (rec.second <= 7'd59) &&
                  (rec.zone_hour <= 7'd23) && (rec.zone_minute <= 7'd59);
          state <= S_QADJ;
        end
        S_QADJ: begin
          q_r   <= div_prod[PROD_W-1:DIV400_SHIFT];
          state <= S_RADJ;
        end
        S_RADJ: begin
          era_r <= q_r;
          yoe_r <= rem;
          doy_r <= 9'(month_offset(rec.month) + 9'(rec.day) - 9'd1);
          state <= S_DOE;
        end
        S_DOE: begin
          doe_r <= 18'(yoe_r) * 18'd365 + 18'(yoe_r >> 2) - 18'(c100) + 18'(doy_r);
          state <= S_DAYS;
        end
        S_DAYS: begin
          days_r <= signed'(days_u - EPOCH_OFFSET);
          state  <= S_SECS1;
        end
        S_SECS1: begin
          dsec_r <= 43'(days_r) * 43'sd86400;
          tod_r  <= 19'(rec.hour) * 19'd3600 + 19'(rec.minute) * 19'd60 + 19'(rec.second);
          zone_r <= 19'(rec.zone_hour) * 19'd3600 + 19'(rec.zone_minute) * 19'd60;
          case (rec.frac_cnt)
            2'd1:    frac_r <= 10'(rec.millis * 10'd100);
            2'd2:    frac_r <= 10'(rec.millis * 10'd10);
            2'd3:    frac_r <= rec.millis;
            default: frac_r <= '0;
          endcase
          state <= S_SECS2;
        end
        S_SECS2: begin
          if (rec.zone_neg) secs_r <= dsec_r + signed'(43'(tod_r)) + signed'(43'(zone_r));
          else secs_r <= dsec_r + signed'(43'(tod_r)) - signed'(43'(zone_r));
          state <= S_MS1;
        end
        S_MS1: begin
          neg_r <= secs_r[42];
          m24_r <= (secs48 << 4) + (secs48 << 3);
          state <= S_MS2;
        end
        S_MS2: begin
          res_valid <= ok_r && !neg_r;
          res_ms    <= (ok_r && !neg_r) ? ms_sum : '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            valid_res <= res_valid;
            epoch_ms  <= res_ms;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for iso_timestamp_to_epoch_ms_core, timestamp text in, epoch ms out
// depends on isoep_pkg for field widths; its own parser and converter predict untyped results
`timescale 1ns / 1ps

module tb_top import isoep_pkg::*; ();

  localparam int RANDOM_CHARS   = 840;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int EPOCH_YEAR     = 1970;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_T     = "T";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_Z     = "Z";
  // stands for a NUL byte in the directed text
  localparam logic [7:0] NUL_MARK = "#";

  typedef enum logic [2:0] {SCAN_FIXED, SCAN_TAIL, SCAN_FRAC, SCAN_ZONE} scan_phase_t;

  typedef struct packed {
    logic        ok;
    logic [47:0] ms;
  } epoch_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [47:0] epoch_ms;

  // parser state mirrored by the predictor
  logic [4:0]          p_pos;
  scan_phase_t         p_phase;
  bit                  p_failed;
  bit                  p_closed;
  logic [YEAR_W-1:0]   p_year;
  logic [FIELD_W-1:0]  p_mon, p_day, p_hour, p_min, p_sec;
  logic [MILLIS_W-1:0] p_millis;
  logic [FCNT_W-1:0]   p_fcnt;
  bit                  p_zneg;
  logic [FIELD_W-1:0]  p_zhour, p_zmin;

  epoch_t     predicted_epochs[$];
  logic [7:0] stamp[$];
  string      row_text[$];
  bit         row_typed[$];
  bit         row_ok[$];
  logic [47:0] row_ms[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;
  int stall_run = 0;

  iso_timestamp_to_epoch_ms_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .epoch_ms  (epoch_ms)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_parser();
    p_pos = '0;
    p_phase = SCAN_FIXED;
    p_failed = 1'b0;
    p_closed = 1'b0;
    p_year = '0;
    p_mon = '0;
    p_day = '0;
    p_hour = '0;
    p_min = '0;
    p_sec = '0;
    p_millis = '0;
    p_fcnt = '0;
    p_zneg = 1'b0;
    p_zhour = '0;
    p_zmin = '0;
  endfunction

  function automatic void take_suffix(logic [7:0] c);
    if (c == CH_Z || c == CH_NUL) begin
      p_closed = 1'b1;
    end else if (c == CH_PLUS || c == CH_DASH) begin
      p_zneg = (c == CH_DASH);
      p_phase = SCAN_ZONE;
      p_pos = '0;
    end else begin
      p_failed = 1'b1;
    end
  endfunction

  // consumes one character; returns 1 with the result when the timestamp ends
  function automatic bit advance_parser(input logic [7:0] c, input logic is_last,
                                        output epoch_t res);
    logic [7:0]  d;
    bit          ok;
    bit          leap;
    int unsigned mlen, y, era, yoe, mp, doy, doe, frac;
    longint      days, zone, secs;
    d = c - CH_ZERO;
    res = '0;
    if (!p_failed && !p_closed) begin
      case (p_phase)
        SCAN_FIXED: begin
          case (p_pos)
            5'd4, 5'd7: if (c != CH_DASH) p_failed = 1'b1;
            5'd10: if (c != CH_T && c != CH_SPACE) p_failed = 1'b1;
            5'd13, 5'd16: if (c != CH_COLON) p_failed = 1'b1;
            default: begin
              if (!is_digit(c)) p_failed = 1'b1;
              else if (p_pos < 4) p_year = YEAR_W'(p_year * 10 + d);
              else if (p_pos < 7) p_mon = FIELD_W'(p_mon * 10 + d);
              else if (p_pos < 10) p_day = FIELD_W'(p_day * 10 + d);
              else if (p_pos < 13) p_hour = FIELD_W'(p_hour * 10 + d);
              else if (p_pos < 16) p_min = FIELD_W'(p_min * 10 + d);
              else p_sec = FIELD_W'(p_sec * 10 + d);
            end
          endcase
          if (!p_failed) begin
            p_pos = p_pos + 5'd1;
            if (p_pos >= 19) begin
              p_phase = SCAN_TAIL;
              p_pos = '0;
            end
          end
        end
        SCAN_TAIL: begin
          if (c == CH_DOT) p_phase = SCAN_FRAC;
          else take_suffix(c);
        end
        SCAN_FRAC: begin
          if (is_digit(c)) begin
            if (p_fcnt < 3) begin
              p_millis = MILLIS_W'(p_millis * 10 + d);
              p_fcnt = p_fcnt + 2'd1;
            end
          end else begin
            take_suffix(c);
          end
        end
        SCAN_ZONE: begin
          if (p_pos == 2) begin
            if (c != CH_COLON) p_failed = 1'b1;
          end else if (!is_digit(c)) begin
            p_failed = 1'b1;
          end else if (p_pos < 2) begin
            p_zhour = FIELD_W'(p_zhour * 10 + d);
          end else begin
            p_zmin = FIELD_W'(p_zmin * 10 + d);
          end
          if (!p_failed) begin
            p_pos = p_pos + 5'd1;
            if (p_pos >= 5) p_closed = 1'b1;
          end
        end
        default: p_failed = 1'b1;
      endcase
    end
    if (!is_last) return 1'b0;

    if (!p_failed && !p_closed) begin
      if (p_phase == SCAN_TAIL || p_phase == SCAN_FRAC) p_closed = 1'b1;
      else p_failed = 1'b1;
    end

    leap = (p_year % 4 == 0 && p_year % 100 != 0) || p_year % 400 == 0;
    case (p_mon)
      7'd2: mlen = leap ? 29 : 28;
      7'd4, 7'd6, 7'd9, 7'd11: mlen = 30;
      default: mlen = 31;
    endcase
    ok = !p_failed && p_closed;
    if (p_year < EPOCH_YEAR || p_mon < 1 || p_mon > 12 || p_day < 1 || p_day > mlen ||
        p_hour > 23 || p_min > 59 || p_sec > 59 || p_zhour > 23 || p_zmin > 59)
      ok = 1'b0;

    if (ok) begin
      // days from civil, march-based year
      y = 32'(p_year) - ((p_mon <= 2) ? 32'd1 : 32'd0);
      era = y / 400;
      yoe = y - era * 400;
      mp = (p_mon > 2) ? 32'(p_mon) - 32'd3 : 32'(p_mon) + 32'd9;
      doy = (153 * mp + 2) / 5 + 32'(p_day) - 32'd1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = longint'(era) * 146097 + longint'(doe) - 719468;
      zone = longint'(p_zhour) * 3600 + longint'(p_zmin) * 60;
      secs = days * 86400 + longint'(p_hour) * 3600 + longint'(p_min) * 60 +
             longint'(p_sec);
      secs = p_zneg ? secs + zone : secs - zone;
      frac = 32'(p_millis);
      for (int n = p_fcnt; n < 3; n++) frac = frac * 10;
      if (secs < 0) begin
        ok = 1'b0;
      end else begin
        res.ms = 48'(secs * 1000 + longint'(frac));
      end
    end
    res.ok = ok;
    if (!ok) res.ms = '0;
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void add_row(string t, bit typed, bit ok, logic [47:0] ms);
    row_text.push_back(t);
    row_typed.push_back(typed);
    row_ok.push_back(ok);
    row_ms.push_back(ms);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic is_last, input bit typed,
                           input bit t_ok, input logic [47:0] t_ms);
    int     gap;
    bit     taken;
    epoch_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= is_last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (advance_parser(c, is_last, res)) begin
      if (typed) begin
        res.ok = t_ok;
        res.ms = t_ms;
      end
      predicted_epochs.push_back(res);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_epochs.size() != 0);
  endtask

  task automatic push_num(int v, int digits);
    int div;
    div = 1;
    repeat (digits - 1) div = div * 10;
    for (int i = 0; i < digits; i++) begin
      stamp.push_back(CH_ZERO + 8'((v / div) % 10));
      div = div / 10;
    end
  endtask

  // mostly well-formed stamps with random fields, some noise and corruption
  task automatic build_stamp();
    int r, yr, mon, day, cut, idx;
    stamp.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 30)) stamp.push_back(8'($urandom_range(255)));
      return;
    end
    r = $urandom_range(99);
    yr = (r < 6) ? $urandom_range(0, 9999) : $urandom_range(EPOCH_YEAR, 9999);
    mon = ($urandom_range(9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    day = ($urandom_range(6) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 28 + r % 4);
    if (r >= 90 && r < 95) begin
      mon = 2;
      day = 29;
    end
    if (r >= 95) begin
      yr = EPOCH_YEAR;
      mon = 1;
      day = 1;
    end
    push_num(yr, 4);
    stamp.push_back(CH_DASH);
    push_num(mon, 2);
    stamp.push_back(CH_DASH);
    push_num(day, 2);
    stamp.push_back($urandom_range(1) ? CH_T : CH_SPACE);
    push_num(($urandom_range(11) == 0) ? $urandom_range(0, 99) :
             (r >= 95 ? $urandom_range(0, 2) : $urandom_range(0, 23)), 2);
    stamp.push_back(CH_COLON);
    push_num(($urandom_range(11) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    stamp.push_back(CH_COLON);
    push_num(($urandom_range(11) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    if ($urandom_range(9) >= 4) begin
      stamp.push_back(CH_DOT);
      repeat ($urandom_range(0, 6)) push_num($urandom_range(0, 9), 1);
    end
    r = $urandom_range(99);
    if (r < 30) begin
      stamp.push_back(CH_Z);
    end else if (r < 40) begin
      stamp.push_back(CH_NUL);
    end else if (r < 80) begin
      stamp.push_back($urandom_range(1) ? CH_PLUS : CH_DASH);
      push_num(($urandom_range(9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
      stamp.push_back(CH_COLON);
      push_num(($urandom_range(9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    end
    if (r < 80 && $urandom_range(9) < 3)
      repeat ($urandom_range(1, 4)) stamp.push_back(8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 12) begin
      idx = $urandom_range(stamp.size() - 1);
      stamp[idx] = 8'($urandom_range(255));
    end else if (r < 17) begin
      cut = $urandom_range(1, stamp.size());
      while (stamp.size() > cut) void'(stamp.pop_back());
    end
  endtask

  // receiver backpressure: free stretches and stalls of mixed length
  always @(posedge clk) begin
    int r;
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      r = $urandom_range(99);
      if (r < 45) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 40);
      end else if (r < 80) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(3, 9);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(19, 39);
      end
    end
  end

  always @(negedge clk) begin : result_check
    epoch_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (predicted_epochs.size() == 0) begin
          report_mismatch($sformatf("unexpected result valid_res=%0b epoch_ms=%0d",
                                    valid_res, epoch_ms));
        end else begin
          want = predicted_epochs.pop_front();
          if (valid_res !== want.ok)
            report_mismatch($sformatf("valid_res %0b, want %0b", valid_res, want.ok));
          if (epoch_ms !== want.ms)
            report_mismatch($sformatf("epoch_ms %0d, want %0d", epoch_ms, want.ms));
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    string      t;
    logic [7:0] c;
    int         sent;
    bit         paused;
    clear_parser();
    //      text                                       typed ok  epoch ms
    add_row("1970-01-01T00:00:00Z",                    1, 1, 48'd0);
    add_row("1970-01-01 00:00:00",                     1, 1, 48'd0);
    add_row("1970-01-01T00:00:00.#",                   1, 1, 48'd0);
    add_row("9999-12-31T23:59:59.999Z",                1, 1, 48'd253402300799999);
    add_row("9999-12-31T23:59:59.999-23:59",           1, 1, 48'd253402387139999);
    add_row("1970-01-01T00:00:00+00:01",               1, 0, 48'd0);
    add_row("1969-12-31T23:59:59-01:00",               1, 0, 48'd0);
    add_row("2000-02-29T12:34:56.5Z",                  0, 0, 48'd0);
    add_row("2100-02-29T00:00:00Z",                    1, 0, 48'd0);
    add_row("2024-13-01T00:00:00Z",                    1, 0, 48'd0);
    add_row("2024-00-10T00:00:00Z",                    1, 0, 48'd0);
    add_row("2024-04-31T00:00:00Z",                    1, 0, 48'd0);
    add_row("2024-01-01T24:00:00Z",                    1, 0, 48'd0);
    add_row("2024-01-01T23:60:00Z",                    1, 0, 48'd0);
    add_row("2024-01-01T23:59:60Z",                    1, 0, 48'd0);
    add_row("2024-06-15T10:20:30+24:00",               1, 0, 48'd0);
    add_row("2024-06-15T10:20:30-00:60",               1, 0, 48'd0);
    add_row("2024-06-15T10:20:3",                      1, 0, 48'd0);
    add_row("2024-06#15T10:20:30Z",                    1, 0, 48'd0);
    add_row("2024-06-15T10:20:30.123456789+05:30",     0, 0, 48'd0);
    add_row("2024-06-15T10:20:30.Z",                   0, 0, 48'd0);
    add_row("2024-06-15T10:20:30+05:3",                1, 0, 48'd0);
    add_row("2024-06-15T10:20:30-05#30",               1, 0, 48'd0);
    add_row("2024/06-15X10.20:30.12aZ",                1, 0, 48'd0);
    add_row("2024-06-15T10:20:30.12aZ",                1, 0, 48'd0);
    add_row("2024-06-15T10:20:30Z\377\200x",           0, 0, 48'd0);
    add_row("2024-06-15T10:20:30#ab",                  0, 0, 48'd0);
    add_row("#",                                       1, 0, 48'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < row_text.size(); r++) begin
      t = row_text[r];
      no_gaps = ($urandom_range(3) == 0);
      for (int i = 0; i < t.len(); i++) begin
        c = t[i];
        if (c == NUL_MARK) c = CH_NUL;
        send_char(c, i == t.len() - 1, row_typed[r], row_ok[r], row_ms[r]);
      end
    end
    hold_until_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_CHARS) begin
      build_stamp();
      no_gaps = ($urandom_range(3) == 0);
      foreach (stamp[i]) send_char(stamp[i], i == stamp.size() - 1, 1'b0, 1'b0, 48'd0);
      sent += stamp.size();
      if (!paused && sent >= RANDOM_CHARS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
